[hdl/sha_pkg.sv]
// Shared types, constants and functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned Rounds      = 64;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;
  localparam logic [5:0]  LenOffset = 6'd56;

  typedef enum logic [0:0] {
    MODE_ABSORB = 1'b0,
    MODE_FINISH = 1'b1
  } mode_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       buf_wr;      // shift a byte into the block window
    logic [5:0] buf_addr;
    logic [7:0] buf_data;
    logic       put_len;     // take the byte from the latched bit count
    logic       load_work;   // copy chain words into working registers
    logic       round_en;    // perform one round at round_idx
    logic [5:0] round_idx;
    logic       fold;        // add working registers into chain words
    logic       add_block;   // add 512 to the bit count
    logic       latch_total; // capture bit count plus fill bits
    logic       restart;     // return chain words and bit count to reset values
  } sha_cmd_t;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  localparam hash_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

[hdl/sha_ctrl.sv]
// Controller state machine: byte absorption, padding, round sequencing and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_byte,
  output sha_cmd_t        cmd,
  output logic            emit,
  output logic [2:0]      emit_idx,
  input  wire logic       emit_ready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       fin_r, fin_nxt;      // finishing message
  logic       final_r, final_nxt;  // this compression is the last one
  logic       acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign emit     = (state_r == ST_OUT);
  assign emit_idx = oidx_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    fin_nxt   = fin_r;
    final_nxt = final_r;
    cmd       = '0;
    cmd.round_idx = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.buf_wr   = 1'b1;
          cmd.buf_addr = fill_r;
          if (in_mode == MODE_ABSORB) begin
            cmd.buf_data = in_byte;
            fill_nxt     = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              cmd.load_work = 1'b1;
              cmd.add_block = 1'b1;
              rnd_nxt   = '0;
              final_nxt = 1'b0;
              state_nxt = ST_ROUND;
            end
          end else begin
            cmd.buf_data    = PadByte;
            cmd.latch_total = 1'b1;
            fin_nxt   = 1'b1;
            fill_nxt  = fill_r + 6'd1;
            state_nxt = ST_PAD;
            if (fill_r == 6'd63) begin
              cmd.load_work = 1'b1;
              rnd_nxt   = '0;
              final_nxt = 1'b0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        // zero-fill; if past the length field, compress an extra block first
        if (fill_r == LenOffset && fill_r != 6'd0 && !final_r) begin
          state_nxt = ST_LEN;
          rnd_nxt   = '0;
        end else begin
          cmd.buf_wr   = 1'b1;
          cmd.buf_addr = fill_r;
          fill_nxt     = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            cmd.load_work = 1'b1;
            rnd_nxt   = '0;
            final_nxt = 1'b0;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        cmd.buf_wr   = 1'b1;
        cmd.put_len  = 1'b1;
        cmd.buf_addr = LenOffset + rnd_r;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'd7) begin
          cmd.load_work = 1'b1;
          rnd_nxt   = '0;
          final_nxt = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        fill_nxt = '0;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (final_r) begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (emit_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.restart = 1'b1;
            fin_nxt   = 1'b0;
            final_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> state_r == ST_FOLD)
    else $error("round count overrun");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && emit_ready && oidx_r == 3'd7) |=> (state_r == ST_IDLE && fill_r == 6'd0))
    else $error("digest end not followed by idle");
  a_fold_only_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD |-> $past(state_r) == ST_ROUND)
    else $error("fold without rounds");

endmodule
`default_nettype wire

[hdl/sha_dp.sv]
// Datapath: byte window and message schedule, round logic, chain words and bit count.
`timescale 1ns / 1ps
`default_nettype none
module sha_dp
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sha_cmd_t   cmd,
  input  wire logic [2:0] emit_idx,
  output word_t           digest_word
);

  word_t       w_r [16];
  hash_t       chain_r;
  word_t       s_r [8];
  logic [63:0] bits_r;
  logic [63:0] total_r;
  logic [7:0]  wr_data;
  word_t       w_cur, w_new, sig0, sig1, t1, t2, ep, ch, mj;
  logic [2:0]  lsel;

  assign lsel = cmd.buf_addr[2:0];
  always_comb begin
    wr_data = cmd.buf_data;
    if (cmd.put_len)
      wr_data = total_r[8*(7 - lsel) +: 8];
  end

  // schedule: first 16 rounds read the byte-loaded window, later ones extend it
  assign sig0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign sig1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + sig0 + w_r[9] + sig1;
  assign w_cur = (cmd.round_idx < 6'd16) ? w_r[0] : w_new;

  assign ep = rotr(s_r[4], 6) ^ rotr(s_r[4], 11) ^ rotr(s_r[4], 25);
  assign ch = (s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6]);
  assign t1 = s_r[7] + ep + ch + round_k(cmd.round_idx) + w_cur;
  assign mj = (s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]);
  assign t2 = (rotr(s_r[0], 2) ^ rotr(s_r[0], 13) ^ rotr(s_r[0], 22)) + mj;

  assign digest_word = chain_r[emit_idx];

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], wr_data};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) s_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end
    if (cmd.latch_total) total_r <= bits_r + {55'd0, cmd.buf_addr, 3'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= InitHash;
      bits_r  <= '0;
    end else begin
      if (cmd.restart) begin
        chain_r <= InitHash;
        bits_r  <= '0;
      end else begin
        if (cmd.fold)
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + s_r[i];
        if (cmd.add_block) bits_r <= bits_r + BlockBits;
      end
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_work && cmd.round_en) && !(cmd.fold && cmd.round_en))
    else $error("conflicting datapath commands");
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> (bits_r == 64'd0 && chain_r == InitHash))
    else $error("restart did not clear state");
  a_bits_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_block && !cmd.restart) |=> bits_r == $past(bits_r) + BlockBits)
    else $error("bit count step wrong");

endmodule
`default_nettype wire

[hdl/sha256_stream_hasher_core.sv]
// Top level of the SHA-256 stream hasher.
// Takes one byte per cycle while absorbing; the 64th byte of a block starts a
// compression that runs 64 rounds, one round per cycle, on a single round unit,
// then a fold, and no byte is taken until it is done; the working registers
// load on the cycle that takes the 64th byte.
// A finish byte (mode 1) writes the pad byte 0x80, then zero bytes and, on
// reaching the length field, the eight length bytes; it compresses once or twice,
// then presents eight digest words, word 0 first, and returns to the initial hash state.
// in_tdata: [7:0] data_byte. in_tuser: mode.
// out_tdata: [31:0] digest_word, [34:32] word_index.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast   // last_word
);

  sha_cmd_t   cmd;
  logic       emit;
  logic [2:0] emit_idx;
  word_t      dword;

  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tuser), .in_byte(in_tdata),
    .cmd, .emit, .emit_idx, .emit_ready(out_tready)
  );

  sha_dp u_dp (
    .clk, .rst_n, .cmd, .emit_idx, .digest_word(dword)
  );

  assign out_tvalid = emit;
  assign out_tdata  = {5'd0, emit_idx, dword};
  assign out_tlast  = (emit_idx == 3'd7);

endmodule
`default_nettype wire
